[rtl/hdes_pkg.sv]
package hdes_pkg;

   // default echo store depth
   localparam int unsigned ECHO_DEPTH_DEF = 256;

   // item kinds carried on req_tuser
   typedef enum logic [1:0] {
      MODE_TX    = 2'd0,
      MODE_RX    = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   // commands from the item decision to the echo store
   typedef struct packed {
      logic       push;
      logic       pop;
      logic       clear;
      logic [7:0] push_byte;
   } fifo_ctl_type;

   // echo store status seen by the item decision
   typedef struct packed {
      logic       empty;
      logic       full;
      logic       one_left;
      logic [7:0] head_byte;
   } fifo_sts_type;

   // one result item
   typedef struct packed {
      logic       push_overflow;
      logic       byte_dropped;
      logic       echo_done;
      logic       deliver_valid;
      logic [7:0] delivered_byte;
   } rsp_type;

endpackage

[rtl/hdes_echo_fifo.sv]
module hdes_echo_fifo #(
   parameter int unsigned ECHO_DEPTH = hdes_pkg::ECHO_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hdes_pkg::fifo_ctl_type ctl,
   output hdes_pkg::fifo_sts_type sts
);

   localparam int unsigned AW = (ECHO_DEPTH > 1) ? $clog2(ECHO_DEPTH) : 1;
   localparam int unsigned CW = $clog2(ECHO_DEPTH + 1);
   localparam logic [AW-1:0] LAST_POS = AW'(ECHO_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(ECHO_DEPTH);
   localparam logic [CW-1:0] ONE_CNT  = CW'(1);

   logic [7:0]    mem [ECHO_DEPTH];
   logic [7:0]    head_byte_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;

   // advance pointers and count
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else if (ctl.push) begin
         tail_in  = (tail_ff == LAST_POS) ? '0 : tail_ff + AW'(1);
         count_in = count_ff + ONE_CNT;
      end else if (ctl.pop) begin
         head_in  = (head_ff == LAST_POS) ? '0 : head_ff + AW'(1);
         count_in = count_ff - ONE_CNT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // write at tail, prefetch the next head entry; forward a same-entry write
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= ctl.push_byte;
      end
      if (ctl.push && (tail_ff == head_in)) begin
         head_byte_ff <= ctl.push_byte;
      end else begin
         head_byte_ff <= mem[head_in];
      end
   end

   assign sts.empty     = (count_ff == '0);
   assign sts.full      = (count_ff == FULL_CNT);
   assign sts.one_left  = (count_ff == ONE_CNT);
   assign sts.head_byte = head_byte_ff;

endmodule

[rtl/half_duplex_echo_suppressor.sv]
// A result item is registered into the output register when its item is taken on req_, or
// into the skid entry while the output is held. Throughput: one item per cycle while the
// skid entry is empty; the echo store head entry is prefetched from the synchronous memory,
// so the compare never waits on a read. A two-entry output stage (register plus skid) keeps
// req_tready independent of rsp_tready. Reset clears pointers, pending count, discard flag
// and output valids; store contents are left as they are and need no clearing pass.
module half_duplex_echo_suppressor #(
   parameter int unsigned ECHO_DEPTH = hdes_pkg::ECHO_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic        req_tlast,   // last_in_chunk
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] delivered_byte
   output logic [3:0]  rsp_tuser    // [0] deliver_valid [1] echo_done
                                    // [2] byte_dropped [3] push_overflow
);

   hdes_pkg::fifo_ctl_type fifo_ctl;
   hdes_pkg::fifo_sts_type fifo_sts;
   hdes_pkg::rsp_type      rsp_new;
   hdes_pkg::rsp_type      out_ff;
   hdes_pkg::rsp_type      skid_ff;
   hdes_pkg::mode_type     mode;

   logic accept;
   logic pop_out;
   logic out_valid_ff;
   logic skid_valid_ff;
   logic discard_ff, discard_in;

   hdes_echo_fifo #(
      .ECHO_DEPTH (ECHO_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .ctl   (fifo_ctl),
      .sts   (fifo_sts)
   );

   assign mode       = hdes_pkg::mode_type'(req_tuser);
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop_out    = out_valid_ff && rsp_tready;

   // decide the item against the echo head
   always_comb begin
      fifo_ctl           = '0;
      fifo_ctl.push_byte = req_tdata;
      rsp_new            = '0;
      discard_in         = discard_ff;
      unique case (mode)
         hdes_pkg::MODE_TX: begin
            rsp_new.push_overflow = fifo_sts.full;
            fifo_ctl.push         = accept && !fifo_sts.full;
         end
         hdes_pkg::MODE_RX: begin
            if (discard_ff) begin
               rsp_new.byte_dropped = 1'b1;
               if (req_tlast) begin
                  discard_in = 1'b0;
               end
            end else if (!fifo_sts.empty) begin
               rsp_new.byte_dropped = 1'b1;
               if (fifo_sts.head_byte == req_tdata) begin
                  fifo_ctl.pop = accept;
               end else begin
                  discard_in = !req_tlast;
               end
            end else begin
               rsp_new.deliver_valid  = 1'b1;
               rsp_new.delivered_byte = req_tdata;
            end
         end
         hdes_pkg::MODE_CLEAR: begin
            fifo_ctl.clear = accept;
            discard_in     = 1'b0;
         end
         default: begin
         end
      endcase
      rsp_new.echo_done = (mode == hdes_pkg::MODE_CLEAR)
                       || (fifo_sts.empty && !fifo_ctl.push && mode != hdes_pkg::MODE_TX)
                       || (fifo_sts.empty && mode == hdes_pkg::MODE_TX && fifo_sts.full)
                       || (fifo_sts.one_left && mode == hdes_pkg::MODE_RX && fifo_ctl.pop);
   end

   // hold the discard flag
   always_ff @(posedge clock) begin
      if (reset) begin
         discard_ff <= 1'b0;
      end else if (accept) begin
         discard_ff <= discard_in;
      end
   end

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop_out) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop_out) begin
            out_ff       <= rsp_new;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= rsp_new;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop_out) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.delivered_byte;
   assign rsp_tuser  = {out_ff.push_overflow, out_ff.byte_dropped,
                        out_ff.echo_done, out_ff.deliver_valid};

   // skid entry only exists behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage valid while output stage empty");

   // discarding only starts on a mismatch with echo pending, and no pop ends it
   a_discard_needs_echo: assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> !fifo_sts.empty)
      else $error("discard flag set with empty echo store");

   // delivered bytes only pass with no echo pending
   a_deliver_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tuser[1] && !rsp_tuser[2] && !rsp_tuser[3]))
      else $error("delivered item also flags drop, overflow or pending echo");

   // an overflow means the store was full, so echo is still pending
   a_overflow_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[3]) |-> !rsp_tuser[1])
      else $error("overflow reported with echo done");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH      = hdes_pkg::ECHO_DEPTH_DEF;
   localparam int unsigned CYCLE_CAP  = 500000;
   localparam int unsigned HOLD_SPAN  = 300;
   localparam int unsigned TAIL_WAIT  = 4;
   // req_tuser code that the block has no use for
   localparam logic [1:0]  MODE_UNUSED = 2'd3;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;   // [7:0] data_byte
   logic [1:0] req_tuser = '0;   // [1:0] mode
   logic       req_tlast = 1'b0; // last_in_chunk
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;        // [7:0] delivered_byte
   logic [3:0] rsp_tuser;        // [0] deliver_valid [1] echo_done
                                 // [2] byte_dropped [3] push_overflow

   // echo tracking state of the predictor
   logic [7:0]  echo_mem [DEPTH];
   int unsigned rd_pos = 0;
   int unsigned wr_pos = 0;
   int unsigned pend_cnt = 0;
   bit          discarding = 1'b0;

   hdes_pkg::rsp_type line_results [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   bit          hold_go = 1'b0;
   bit          hold_seen = 1'b0;
   int unsigned hold_left = 0;

   half_duplex_echo_suppressor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // abort a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // count down one long receiver hold-off each time it is armed
   always @(posedge clock) begin
      if (!hold_go) begin
         hold_seen <= 1'b0;
      end else if (!hold_seen) begin
         hold_seen <= 1'b1;
      end
      if (hold_go && !hold_seen) begin
         hold_left <= HOLD_SPAN;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver: stall at random, or hard during a hold-off
   always @(posedge clock) begin
      if (reset || hold_left != 0) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch %s: got %0h, expected %0h (cycle %0d)", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // compare each taken result item with the oldest expectation
   always @(posedge clock) begin : result_check
      hdes_pkg::rsp_type got;
      hdes_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata};
         if (line_results.size() == 0) begin
            report_mismatch("unexpected result item", got[7:0], 8'h00);
         end else begin
            want = line_results.pop_front();
            if (got.deliver_valid !== want.deliver_valid)
               report_mismatch("deliver_valid", 8'(got.deliver_valid),
                               8'(want.deliver_valid));
            if (got.delivered_byte !== want.delivered_byte)
               report_mismatch("delivered_byte", got.delivered_byte, want.delivered_byte);
            if (got.echo_done !== want.echo_done)
               report_mismatch("echo_done", 8'(got.echo_done), 8'(want.echo_done));
            if (got.byte_dropped !== want.byte_dropped)
               report_mismatch("byte_dropped", 8'(got.byte_dropped),
                               8'(want.byte_dropped));
            if (got.push_overflow !== want.push_overflow)
               report_mismatch("push_overflow", 8'(got.push_overflow),
                               8'(want.push_overflow));
         end
      end
   end

   // advance the echo tracking state by one item and queue its result
   task automatic predict_line_item(input logic [1:0] mode, input logic [7:0] data,
                                    input logic last);
      hdes_pkg::rsp_type r;
      r = '0;
      case (mode)
         hdes_pkg::MODE_TX: begin
            if (pend_cnt >= DEPTH) begin
               r.push_overflow = 1'b1;
            end else begin
               echo_mem[wr_pos] = data;
               wr_pos = (wr_pos == DEPTH - 1) ? 0 : wr_pos + 1;
               pend_cnt++;
            end
         end
         hdes_pkg::MODE_RX: begin
            if (discarding) begin
               r.byte_dropped = 1'b1;
               if (last) discarding = 1'b0;
            end else if (pend_cnt != 0) begin
               r.byte_dropped = 1'b1;
               if (echo_mem[rd_pos] == data) begin
                  rd_pos = (rd_pos == DEPTH - 1) ? 0 : rd_pos + 1;
                  pend_cnt--;
               end else begin
                  discarding = !last;
               end
            end else begin
               r.deliver_valid  = 1'b1;
               r.delivered_byte = data;
            end
         end
         hdes_pkg::MODE_CLEAR: begin
            rd_pos     = 0;
            wr_pos     = 0;
            pend_cnt   = 0;
            discarding = 1'b0;
         end
         default: begin
            // unused kind leaves everything as it is
         end
      endcase
      r.echo_done = (pend_cnt == 0);
      line_results.push_back(r);
   endtask

   // offer one item after a random gap, hold it until taken
   task automatic offer_line_item(input logic [1:0] mode, input logic [7:0] data,
                                  input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_line_item(mode, data, last);
   endtask

   // stop offering and wait for every expected result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (line_results.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
   endtask

   // field extremes, every kind and each echo corner
   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      offer_line_item(hdes_pkg::MODE_RX, 8'h00, 1'b0);
      offer_line_item(hdes_pkg::MODE_RX, 8'hFF, 1'b1);
      offer_line_item(MODE_UNUSED, 8'hA5, 1'b1);
      offer_line_item(hdes_pkg::MODE_TX, 8'h00, 1'b0);
      offer_line_item(hdes_pkg::MODE_TX, 8'hFF, 1'b1);
      offer_line_item(hdes_pkg::MODE_TX, 8'h5A, 1'b0);
      offer_line_item(MODE_UNUSED, 8'h3C, 1'b0);
      offer_line_item(hdes_pkg::MODE_RX, 8'h00, 1'b0);
      // mismatch in mid chunk starts discarding
      offer_line_item(hdes_pkg::MODE_RX, 8'h12, 1'b0);
      offer_line_item(hdes_pkg::MODE_TX, 8'h77, 1'b0);
      offer_line_item(hdes_pkg::MODE_RX, 8'hFF, 1'b0);
      offer_line_item(hdes_pkg::MODE_RX, 8'h33, 1'b1);
      offer_line_item(hdes_pkg::MODE_RX, 8'hFF, 1'b1);
      // mismatch on the last byte of a chunk does not discard
      offer_line_item(hdes_pkg::MODE_RX, 8'h99, 1'b1);
      offer_line_item(hdes_pkg::MODE_RX, 8'h5A, 1'b0);
      offer_line_item(hdes_pkg::MODE_RX, 8'h77, 1'b1);
      offer_line_item(hdes_pkg::MODE_RX, 8'hC3, 1'b1);
      // clear while discarding with echo pending
      offer_line_item(hdes_pkg::MODE_TX, 8'h11, 1'b0);
      offer_line_item(hdes_pkg::MODE_RX, 8'h22, 1'b0);
      offer_line_item(hdes_pkg::MODE_CLEAR, 8'hFF, 1'b1);
      offer_line_item(hdes_pkg::MODE_RX, 8'h44, 1'b0);
      offer_line_item(hdes_pkg::MODE_CLEAR, 8'h00, 1'b0);
      drain_results();
   endtask

   // fill the store to overflow across the pointer wrap, then echo it all back
   task automatic test_full_store();
      logic [7:0] pushed [$];
      logic [7:0] b;
      send_idle_pct = 0;
      rsp_stall_pct = 20;
      for (int i = 0; i < 5; i++) begin
         b = 8'($urandom);
         offer_line_item(hdes_pkg::MODE_TX, b, 1'b0);
         offer_line_item(hdes_pkg::MODE_RX, b, 1'b1);
      end
      for (int i = 0; i < DEPTH + 3; i++) begin
         b = 8'($urandom);
         if (i < DEPTH) pushed.push_back(b);
         offer_line_item(hdes_pkg::MODE_TX, b, 1'($urandom));
      end
      foreach (pushed[i]) begin
         offer_line_item(hdes_pkg::MODE_RX, pushed[i], i == DEPTH - 1);
      end
      offer_line_item(hdes_pkg::MODE_RX, 8'hA5, 1'b1);
      drain_results();
   endtask

   // transmit bursts with their echoes and replies, plus some noise
   task automatic run_random_phase(input int unsigned items, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
      logic [7:0]  burst [$];
      logic [7:0]  b;
      int unsigned sent;
      int unsigned n;
      int unsigned bad_at;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(9) == 0) begin
            offer_line_item(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
            sent++;
         end else begin
            // recover from a stuck store now and then
            if (pend_cnt != 0 && $urandom_range(1) == 0) begin
               offer_line_item(hdes_pkg::MODE_CLEAR, 8'($urandom), 1'($urandom));
               sent++;
            end
            n = $urandom_range(1, 8);
            burst.delete();
            for (int i = 0; i < n; i++) begin
               b = 8'($urandom);
               burst.push_back(b);
               offer_line_item(hdes_pkg::MODE_TX, b, 1'($urandom));
            end
            bad_at = ($urandom_range(6) == 0) ? $urandom_range(n - 1) : n;
            for (int i = 0; i < n; i++) begin
               b = burst[i];
               if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
               offer_line_item(hdes_pkg::MODE_RX, b,
                               (i == n - 1) || ($urandom_range(3) == 0));
            end
            sent += 2 * n;
            // reply chunk from the far end
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
               offer_line_item(hdes_pkg::MODE_RX, 8'($urandom), i == n - 1);
            end
            sent += n;
         end
      end
      drain_results();
   endtask

   // hold the receiver off so the block fills and stalls its input
   task automatic test_backpressure();
      logic [7:0] b;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_go <= 1'b1;
      for (int i = 0; i < 30; i++) begin
         b = 8'($urandom);
         offer_line_item(hdes_pkg::MODE_TX, b, 1'b0);
         offer_line_item(hdes_pkg::MODE_RX, b, 1'($urandom));
      end
      hold_go <= 1'b0;
      drain_results();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_store();
      test_backpressure();
      run_random_phase(150, 0, 0);
      run_random_phase(150, 82, 0);
      run_random_phase(150, 0, 82);
      run_random_phase(150, 10, 10);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
